// File: hdl/hce_pkg.sv
// Shared types, constants and Huffman code tables for the coefficient encoder.
// Used by hce_front, hce_queue, hce_back and the top level.
`default_nettype none

package hce_pkg;

  localparam int MAX_CATEGORY_DEF = 10;
  localparam int MAX_CODE_LENGTH  = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int CAT_W   = 4;   // categories 0..11
  localparam int LEN_W   = 5;   // code lengths 0..16
  localparam int FIELD_W = 27;  // code plus magnitude bits, left aligned
  localparam int WORK_W  = 40;  // pending byte plus field

  typedef enum logic [1:0] {
    OP_DC    = 2'd0,
    OP_AC    = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_t;

  typedef struct packed {
    logic               err;
    logic               flush;
    logic [FIELD_W-1:0] bits;
    logic [LEN_W:0]     len;
  } job_t;

  localparam logic [7:0] DC_COUNTS [MAX_CODE_LENGTH] = '{
    8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [7:0] DC_SYMS [12] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11
  };

  localparam logic [7:0] AC_COUNTS [MAX_CODE_LENGTH] = '{
    8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d
  };

  localparam logic [7:0] AC_SYMS [162] = '{
    8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,
    8'h21,8'h31,8'h41,8'h06,8'h13,8'h51,8'h61,8'h07,
    8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
    8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,
    8'h24,8'h33,8'h62,8'h72,8'h82,8'h09,8'h0a,8'h16,
    8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
    8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,
    8'h3a,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
    8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
    8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
    8'h6a,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,
    8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
    8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,
    8'h99,8'h9a,8'ha2,8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,
    8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
    8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,
    8'hc6,8'hc7,8'hc8,8'hc9,8'hca,8'hd2,8'hd3,8'hd4,
    8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
    8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,
    8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,8'hf7,8'hf8,
    8'hf9,8'hfa
  };

  // Canonical code table: entry = {length, code}, indexed by symbol.
  function automatic logic [255:0][20:0] build_code_table(input logic is_ac);
    logic [255:0][20:0] t;
    logic [16:0]        code;
    logic [7:0]         cnt;
    logic [7:0]         sym;
    int                 k;
    int                 nsyms;
    t     = '0;
    code  = '0;
    k     = 0;
    nsyms = is_ac ? 162 : 12;
    for (int l = 0; l < MAX_CODE_LENGTH; l++) begin
      if (is_ac) begin
        cnt = AC_COUNTS[l];
      end else begin
        cnt = DC_COUNTS[l];
      end
      for (int n = 0; n < 256; n++) begin
        if (n < int'(cnt) && k < nsyms) begin
          if (is_ac) begin
            sym = AC_SYMS[k];
          end else begin
            sym = DC_SYMS[k];
          end
          t[sym] = {5'(l + 1), code[15:0]};
          code   = code + 17'd1;
          k      = k + 1;
        end
      end
      code = code << 1;
    end
    return t;
  endfunction

  localparam logic [255:0][20:0] DC_TABLE = build_code_table(1'b0);
  localparam logic [255:0][20:0] AC_TABLE = build_code_table(1'b1);

endpackage

`default_nettype wire

// File: hdl/hce_front.sv
// Front end: classifies a symbol, finds its category and Huffman code and
// builds the left-aligned bit field for the packer. Depends on hce_pkg.
`default_nettype none

module hce_front import hce_pkg::*; #(
  parameter int MAX_CATEGORY = MAX_CATEGORY_DEF
) (
  input  wire logic        [1:0]  opcode,
  input  wire logic        [3:0]  zero_run,
  input  wire logic signed [10:0] coef_value,
  output job_t                    job
);

  logic [11:0]       vx;
  logic [11:0]       abs_v;
  logic [11:0]       vm1;
  logic [CAT_W-1:0]  raw_cat;
  logic [CAT_W-1:0]  cat;
  logic [10:0]       src;
  logic [10:0]       mask;
  logic [10:0]       mag;
  logic [10:0]       mag_l;
  logic [20:0]       entry;
  logic [LEN_W-1:0]  clen;
  logic [15:0]       code_l;
  logic [FIELD_W-1:0] field;
  logic              ac_err;

  always_comb begin
    vx    = {coef_value[10], coef_value};
    abs_v = coef_value[10] ? (~vx + 12'd1) : vx;
    vm1   = vx - 12'd1;
    raw_cat = '0;
    for (int i = 0; i < 12; i++) begin
      if (abs_v[i]) raw_cat = CAT_W'(i + 1);
    end
    cat = (raw_cat > CAT_W'(MAX_CATEGORY)) ? CAT_W'(MAX_CATEGORY) : raw_cat;

    // negative values send value - 1 in cat bits
    src   = coef_value[10] ? vm1[10:0] : coef_value;
    mask  = 11'((12'd1 << cat) - 12'd1);
    mag   = src & mask;
    mag_l = 11'(mag << (4'd11 - cat));

    if (opcode == OP_DC) begin
      entry = DC_TABLE[{4'd0, cat}];
    end else begin
      entry = AC_TABLE[{zero_run, cat}];
    end
    clen   = entry[20:16];
    code_l = 16'(entry[15:0] << (5'd16 - clen));
    field  = {code_l, 11'd0} | FIELD_W'({mag_l, 16'd0} >> clen);

    ac_err = ((coef_value == 11'sd0) && (zero_run != 4'd0) && (zero_run != 4'd15))
             || (cat > 4'd10);

    job = '0;
    unique case (opcode)
      OP_DC: begin
        job.bits = field;
        job.len  = (LEN_W + 1)'(clen) + (LEN_W + 1)'(cat);
      end
      OP_AC: begin
        if (ac_err) begin
          job.err = 1'b1;
        end else begin
          job.bits = field;
          job.len  = (LEN_W + 1)'(clen) + (LEN_W + 1)'(cat);
        end
      end
      OP_FLUSH: job.flush = 1'b1;
      default: ;  // unused opcode: status only, nothing written
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/hce_queue.sv
// Short job queue between the classifier and the bit packer.
// Depends on hce_pkg for the job type.
`default_nettype none

module hce_queue import hce_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full   = (count == (AW + 1)'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW + 1)'(wr_en) - (AW + 1)'(rd_en);
    end
  end

endmodule

`default_nettype wire

// File: hdl/hce_back.sv
// Back end: bit packer; merges a job into the pending byte and sends completed
// bytes to the result register, one per cycle while free. Depends on hce_pkg.
`default_nettype none

module hce_back import hce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire job_t       job,
  input  wire logic       job_empty,
  output logic            job_pop,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            coding_error,
  output logic            last_result,
  output logic            empty,
  input  wire logic       pop
);

  logic              active;
  logic              job_err;
  logic [WORK_W-1:0] work;
  logic [5:0]        cnt;
  logic [7:0]        pending_bits;
  logic [2:0]        pending_count;
  logic              out_valid;
  logic              out_free;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign job_pop  = !active && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      job_err       <= 1'b0;
      cnt           <= '0;
      pending_bits  <= '0;
      pending_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (job_pop) begin
        if (pop) out_valid <= 1'b0;
        active  <= 1'b1;
        job_err <= job.err;
        if (job.flush) begin
          work <= {pending_bits, 32'd0};
          cnt  <= (pending_count != 3'd0) ? 6'd8 : 6'd0;
        end else begin
          work <= {pending_bits, 32'd0} | ({job.bits, 13'd0} >> pending_count);
          cnt  <= 6'(pending_count) + 6'(job.len);
        end
      end else if (active && out_free) begin
        out_valid <= 1'b1;
        if (job_err) begin
          out_byte     <= '0;
          byte_valid   <= 1'b0;
          coding_error <= 1'b1;
          last_result  <= 1'b1;
          active       <= 1'b0;
        end else if (cnt >= 6'd8) begin
          out_byte     <= work[WORK_W-1 -: 8];
          byte_valid   <= 1'b1;
          coding_error <= 1'b0;
          last_result  <= (cnt < 6'd16);
          work         <= work << 8;
          cnt          <= cnt - 6'd8;
          if (cnt < 6'd16) begin
            // leftover bits become the new pending byte
            active        <= 1'b0;
            pending_bits  <= work[WORK_W-9 -: 8];
            pending_count <= cnt[2:0];
          end
        end else begin
          out_byte      <= '0;
          byte_valid    <= 1'b0;
          coding_error  <= 1'b0;
          last_result   <= 1'b1;
          active        <= 1'b0;
          pending_bits  <= work[WORK_W-1 -: 8];
          pending_count <= cnt[2:0];
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    pending_count == 3'd0 |-> pending_bits == 8'd0)
    else $error("pending bits set with empty packer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    active && !job_err |-> cnt <= 6'd34)
    else $error("packer bit count out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    active && !job_pop && out_free && !job_err && cnt >= 6'd8 && cnt < 6'd16 |=> !active)
    else $error("packer stayed busy after final byte");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !active)
    else $error("job taken while packer busy");

endmodule

`default_nettype wire

// File: hdl/jpeg_huffman_coefficient_encoder_core.sv
// JPEG baseline Huffman coefficient encoder: front classifier, job queue, packer.
// An accepted item goes via a queue slot and the packer's work register to the result
// register, giving 1..4 results. The packer takes an item only when done with the last
// and sends one byte per cycle while its output is free; the front takes an item per
// cycle with queue room. Reset (rst, synchronous) empties queue and packer.
`default_nettype none

module jpeg_huffman_coefficient_encoder_core import hce_pkg::*; #(
  parameter int MAX_CATEGORY = MAX_CATEGORY_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic        [1:0]  opcode,
  input  wire logic        [3:0]  zero_run,
  input  wire logic signed [10:0] coef_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic             [7:0]  out_byte,
  output logic                    byte_valid,
  output logic                    coding_error,
  output logic                    last_result
);

  job_t front_job;
  job_t queue_job;
  logic queue_empty;
  logic queue_pop;

  hce_front #(.MAX_CATEGORY(MAX_CATEGORY)) u_front (
    .opcode     (opcode),
    .zero_run   (zero_run),
    .coef_value (coef_value),
    .job        (front_job)
  );

  hce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !full),
    .wr_job (front_job),
    .full   (full),
    .rd_en  (queue_pop),
    .rd_job (queue_job),
    .empty  (queue_empty)
  );

  hce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job          (queue_job),
    .job_empty    (queue_empty),
    .job_pop      (queue_pop),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .coding_error (coding_error),
    .last_result  (last_result),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for jpeg_huffman_coefficient_encoder_core.
// Predicts packed bytes and error status per item; depends on hce_pkg and the core RTL.
`default_nettype none

module testbench;
  import hce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       err;
    logic       last;
  } byte_res_t;

  // Scoreboard: holds packer state and the queue of expected bytes.
  class packer_scoreboard;
    byte_res_t   expected_q[$];
    logic [7:0]  acc_bits;
    int          acc_count;
    int          errors;
    byte_res_t   item_res[$];

    function new();
      acc_bits  = '0;
      acc_count = 0;
      errors    = 0;
    endfunction

    // Canonical code lookup built from the count/symbol lists.
    function automatic bit lookup(bit is_ac, int sym, output int code, output int len);
      int c, k, nsyms, cnt, s;
      c = 0;
      k = 0;
      nsyms = is_ac ? 162 : 12;
      for (int l = 1; l <= MAX_CODE_LENGTH; l++) begin
        cnt = is_ac ? int'(AC_COUNTS[l-1]) : int'(DC_COUNTS[l-1]);
        for (int n = 0; n < cnt && k < nsyms; n++) begin
          s = is_ac ? int'(AC_SYMS[k]) : int'(DC_SYMS[k]);
          if (s == sym) begin
            code = c;
            len  = l;
            return 1'b1;
          end
          c++;
          k++;
        end
        c = c << 1;
      end
      return 1'b0;
    endfunction

    function void shift_in(int unsigned value, int len);
      byte_res_t r;
      for (int i = len - 1; i >= 0; i--) begin
        if ((value >> i) & 1) acc_bits[7 - acc_count] = 1'b1;
        acc_count++;
        if (acc_count == 8) begin
          r = '{acc_bits, 1'b1, 1'b0, 1'b0};
          item_res.push_back(r);
          acc_bits  = '0;
          acc_count = 0;
        end
      end
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] run, logic signed [10:0] val);
      int v, mag, cat, code, len, bits;
      bit ok;
      byte_res_t r;
      item_res.delete();
      v = val;
      if (op == OP_DC || op == OP_AC) begin
        mag = v < 0 ? -v : v;
        cat = 0;
        while (cat < 12 && (mag >> cat) != 0) cat++;
        if (cat > MAX_CATEGORY_DEF) cat = MAX_CATEGORY_DEF;
        code = 0;
        len  = 0;
        if (op == OP_DC) ok = lookup(1'b0, cat, code, len);
        else if (v == 0 && run != 0 && run != 15) ok = 1'b0;
        else if (cat > 10) ok = 1'b0;
        else ok = lookup(1'b1, (int'(run) << 4) | cat, code, len);
        if (!ok) begin
          r = '{8'h00, 1'b0, 1'b1, 1'b1};
          expected_q.push_back(r);
          return;
        end
        bits = 0;
        if (cat > 0) bits = (v >= 0 ? v : v + (1 << cat) - 1) & ((1 << cat) - 1);
        shift_in(code, len);
        shift_in(bits, cat);
      end else if (op == OP_FLUSH) begin
        if (acc_count != 0) item_res.push_back('{acc_bits, 1'b1, 1'b0, 1'b0});
        acc_bits  = '0;
        acc_count = 0;
      end
      if (item_res.size() == 0) item_res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
      item_res[item_res.size() - 1].last = 1'b1;
      foreach (item_res[i]) expected_q.push_back(item_res[i]);
    endfunction

    function void check_result(byte_res_t got);
      byte_res_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result byte=%0h valid=%0b err=%0b last=%0b",
               got.data, got.valid, got.err, got.last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.data !== e.data) begin
        $error("out_byte: expected %0h, actual %0h", e.data, got.data);
        errors++;
      end
      if (got.valid !== e.valid) begin
        $error("byte_valid: expected %0b, actual %0b", e.valid, got.valid);
        errors++;
      end
      if (got.err !== e.err) begin
        $error("coding_error: expected %0b, actual %0b", e.err, got.err);
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last_result: expected %0b, actual %0b", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic        [1:0]  opcode = '0;
  logic        [3:0]  zero_run = '0;
  logic signed [10:0] coef_value = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic        [7:0]  out_byte;
  logic               byte_valid;
  logic               coding_error;
  logic               last_result;

  packer_scoreboard sb = new();
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  stall_mode = 1'b0;
  bit  sending_done = 1'b0;

  localparam int CYCLE_LIMIT = 200000;

  always #4 clk = ~clk;

  jpeg_huffman_coefficient_encoder_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .zero_run(zero_run), .coef_value(coef_value), .empty(empty), .pop(pop),
    .out_byte(out_byte), .byte_valid(byte_valid), .coding_error(coding_error),
    .last_result(last_result)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until accepted; push stays high for a
  // following item with no gap.
  task automatic send_item(logic [1:0] op, logic [3:0] run, logic signed [10:0] val);
    int g;
    g = stall_mode ? 0 : gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push       <= 1'b1;
    opcode     <= op;
    zero_run   <= run;
    coef_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(op, run, val);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [10:0] rand_value();
    int p;
    p = $urandom_range(0, 9);
    if (p < 2) return 11'($urandom_range(0, 2047));
    if (p < 4) return 11'sd0;
    return 11'($signed($urandom_range(0, 30)) - 15);
  endfunction

  task automatic random_block();
    int n;
    send_item(OP_DC, 4'd0, rand_value());
    n = $urandom_range(0, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_AC, 4'd15, 11'sd0);
      else send_item(OP_AC, 4'($urandom_range(0, 15)), rand_value());
    end
    if ($urandom_range(0, 3) != 0) send_item(OP_AC, 4'd0, 11'sd0);
    if ($urandom_range(0, 2) == 0) send_item(OP_FLUSH, 4'($urandom), 11'($urandom));
  endtask

  // Receiver: random pop, with one long hold-off counted here.
  always @(posedge clk) begin
    if (!rst) begin
      if (!empty && pop) sb.check_result({out_byte, byte_valid, coding_error, last_result});
      if (stall_mode) begin
        pop <= 1'b0;
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles >= 60) stall_mode <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 9) < 7) || sending_done;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, EOB, ZRL, invalid zero, -1024, opcode 3, flushes.
    send_item(OP_FLUSH, 4'd0, 11'sd0);
    send_item(OP_DC, 4'd0, 11'sd0);
    send_item(OP_DC, 4'd0, 11'sd1023);
    send_item(OP_DC, 4'd0, -11'sd1023);
    send_item(OP_DC, 4'd0, -11'sd1024);
    send_item(OP_AC, 4'd0, 11'sd1);
    send_item(OP_AC, 4'd15, 11'sd1023);
    send_item(OP_AC, 4'd15, -11'sd1024);
    send_item(OP_AC, 4'd7, -11'sd1);
    send_item(OP_AC, 4'd15, 11'sd0);
    send_item(OP_AC, 4'd5, 11'sd0);
    send_item(OP_AC, 4'd1, 11'sd0);
    send_item(OP_AC, 4'd0, 11'sd0);
    send_item(2'd3, 4'd9, 11'sd77);
    send_item(OP_FLUSH, 4'd15, -11'sd1);
    send_item(OP_FLUSH, 4'd0, 11'sd0);
    drain();
    // Long receiver hold-off while items keep coming.
    hold_cycles = 0;
    stall_mode  = 1'b1;
    for (int i = 0; i < 10; i++) send_item(OP_AC, 4'($urandom), 11'sd600);
    drain();
    for (int b = 0; b < 40; b++) begin
      random_block();
      if ($urandom_range(0, 4) == 0)
        send_item(2'($urandom), 4'($urandom), 11'($urandom));
      if (b == 20) drain();
    end
    send_item(OP_FLUSH, 4'd0, 11'sd0);
    sending_done = 1'b1;
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

`default_nettype wire
